// ----- hdl/tsr_pkg.sv -----
`default_nettype none
package tsr_pkg;

    localparam int ENTRY_SLOTS     = 16;
    localparam int ENTRY_MAX_BYTES = 512;
    localparam int ENTRY_WORDS     = (ENTRY_MAX_BYTES + 7) / 8;
    localparam int WORD_W          = $clog2(ENTRY_WORDS);
    localparam int SLOT_W          = $clog2(ENTRY_SLOTS);
    localparam int PAY_SLOT_W      = SLOT_W + 1;
    localparam int PAY_DEPTH       = (ENTRY_SLOTS + 1) << WORD_W;
    localparam int CNT_W           = 5;
    localparam int LEN_W           = 10;
    localparam int BYTES_W         = 14;
    localparam int CTR_W           = WORD_W + 1;
    localparam int STAMP_W         = 64;
    localparam int META_W          = LEN_W + STAMP_W;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 32;

    localparam logic [CNT_W-1:0]      LIMIT_RESET     = CNT_W'(16);
    localparam logic [LEN_W-1:0]      BYTE_LIM_RESET  = LEN_W'(512);
    localparam logic [CFG_DATA_W-1:0] RETENTION_RESET = CFG_DATA_W'(24 * 60 * 60 * 1000);

    typedef enum logic [2:0] {
        CMD_PUSH   = 3'd0,
        CMD_POP    = 3'd1,
        CMD_PEEK   = 3'd2,
        CMD_DROP   = 3'd3,
        CMD_CLEAR  = 3'd4,
        CMD_EXPIRE = 3'd5,
        CMD_STATUS = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_TOO_LONG = 2'd2,
        ST_ROOM     = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENTRY_LIMIT = 2'd0,
        CFG_BYTE_LIMIT  = 2'd1,
        CFG_RETENTION   = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE, S_LOOK, S_EXEC, S_COPY_RD, S_COPY_WR, S_COMMIT,
        S_SNAP, S_RESULT, S_WORD_RD, S_WORD_OUT
    } t_state;

    // Controller to datapath strobes
    typedef struct packed {
        logic    latch;
        logic    asm_push;
        logic    asm_clear;
        logic    remove;
        logic    set_st;
        t_status st;
        logic    set_len;
        logic    clear_ring;
        logic    rem_inc;
        logic    ctr_clr;
        logic    ctr_inc;
        logic    save_rd;
        logic    rd_asm;
        logic    copy_wr;
        logic    commit;
        logic    load_result;
        logic    load_word;
    } t_dp_cmd;

    // Datapath to controller flags
    typedef struct packed {
        t_cmd cmd;
        logic last_word;
        logic reject;
        logic empty;
        logic full;
        logic room_short;
        logic expire_hit;
        logic wa_zero;
        logic copy_done;
        logic word_last;
        logic out_free;
    } t_dp_stat;

    function automatic logic [63:0] byte_mask(input logic [3:0] n);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < n) m[i*8 +: 8] = 8'hff;
        end
        return m;
    endfunction

    function automatic logic [CNT_W-1:0] eff_limit(input logic [CNT_W-1:0] v);
        if (v == '0) return CNT_W'(1);
        if (v > CNT_W'(ENTRY_SLOTS)) return CNT_W'(ENTRY_SLOTS);
        return v;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/tsr_in_if.sv -----
`default_nettype none
interface tsr_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [63:0] data_word;
    logic [3:0]  word_bytes;
    logic        last_word;
    logic [63:0] now_ms;
    logic [9:0]  room;

    modport source (output valid, cmd, data_word, word_bytes, last_word, now_ms, room,
                    input ready);
    modport sink   (input valid, cmd, data_word, word_bytes, last_word, now_ms, room,
                    output ready);
endinterface
`default_nettype wire

// ----- hdl/tsr_out_if.sv -----
`default_nettype none
interface tsr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] out_word;
    logic [3:0]  out_bytes;
    logic        out_last;
    logic [9:0]  entry_length;
    logic [4:0]  stored_count;
    logic [4:0]  free_slots;
    logic        is_full;
    logic [13:0] total_bytes;
    logic [63:0] oldest_time;
    logic [63:0] newest_time;
    logic [4:0]  removed_count;

    modport source (output valid, status, out_word, out_bytes, out_last, entry_length,
                    stored_count, free_slots, is_full, total_bytes, oldest_time,
                    newest_time, removed_count, input ready);
    modport sink   (input valid, status, out_word, out_bytes, out_last, entry_length,
                    stored_count, free_slots, is_full, total_bytes, oldest_time,
                    newest_time, removed_count, output ready);
endinterface
`default_nettype wire

// ----- hdl/tsr_ram.sv -----
`default_nettype none
module tsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ----- hdl/tsr_ctrl.sv -----
`default_nettype none
module tsr_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire tsr_pkg::t_dp_stat i_stat,
    output tsr_pkg::t_dp_cmd       o_cmd
);
    tsr_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // One item: look-up, execution, snapshot and result, or word read-out
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.st   = tsr_pkg::ST_OK;
        case (r_state)
            tsr_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = tsr_pkg::S_LOOK;
                end
            end
            tsr_pkg::S_LOOK: begin
                n_state = tsr_pkg::S_EXEC;
            end
            tsr_pkg::S_EXEC: begin
                n_state = tsr_pkg::S_SNAP;
                case (i_stat.cmd)
                    tsr_pkg::CMD_PUSH: begin
                        if (!i_stat.last_word) begin
                            o_cmd.asm_push = 1'b1;
                        end else if (i_stat.reject) begin
                            o_cmd.set_st    = 1'b1;
                            o_cmd.st        = tsr_pkg::ST_TOO_LONG;
                            o_cmd.asm_clear = 1'b1;
                        end else begin
                            o_cmd.remove  = i_stat.full;
                            o_cmd.ctr_clr = 1'b1;
                            n_state = i_stat.wa_zero ? tsr_pkg::S_COMMIT : tsr_pkg::S_COPY_RD;
                        end
                    end
                    tsr_pkg::CMD_POP, tsr_pkg::CMD_PEEK: begin
                        if (i_stat.empty) begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = tsr_pkg::ST_EMPTY;
                        end else if (i_stat.room_short) begin
                            o_cmd.set_len = 1'b1;
                            o_cmd.set_st  = 1'b1;
                            o_cmd.st      = tsr_pkg::ST_ROOM;
                        end else begin
                            o_cmd.set_len = 1'b1;
                            o_cmd.remove  = (i_stat.cmd == tsr_pkg::CMD_POP);
                            o_cmd.save_rd = 1'b1;
                            o_cmd.ctr_clr = 1'b1;
                            n_state       = tsr_pkg::S_WORD_RD;
                        end
                    end
                    tsr_pkg::CMD_DROP: begin
                        if (i_stat.empty) begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = tsr_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.remove  = 1'b1;
                            o_cmd.rem_inc = 1'b1;
                        end
                    end
                    tsr_pkg::CMD_CLEAR: begin
                        o_cmd.clear_ring = 1'b1;
                    end
                    tsr_pkg::CMD_EXPIRE: begin
                        // Remove one aged entry, then look at the new oldest
                        if (i_stat.expire_hit) begin
                            o_cmd.remove  = 1'b1;
                            o_cmd.rem_inc = 1'b1;
                            n_state       = tsr_pkg::S_LOOK;
                        end
                    end
                    default: begin
                        n_state = tsr_pkg::S_SNAP;
                    end
                endcase
            end
            tsr_pkg::S_COPY_RD: begin
                o_cmd.rd_asm = 1'b1;
                n_state      = tsr_pkg::S_COPY_WR;
            end
            tsr_pkg::S_COPY_WR: begin
                o_cmd.copy_wr = 1'b1;
                o_cmd.ctr_inc = 1'b1;
                n_state = i_stat.copy_done ? tsr_pkg::S_COMMIT : tsr_pkg::S_COPY_RD;
            end
            tsr_pkg::S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = tsr_pkg::S_SNAP;
            end
            tsr_pkg::S_SNAP: begin
                n_state = tsr_pkg::S_RESULT;
            end
            tsr_pkg::S_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_result = 1'b1;
                    n_state           = tsr_pkg::S_IDLE;
                end
            end
            tsr_pkg::S_WORD_RD: begin
                n_state = tsr_pkg::S_WORD_OUT;
            end
            tsr_pkg::S_WORD_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_word = 1'b1;
                    o_cmd.ctr_inc   = 1'b1;
                    n_state = i_stat.word_last ? tsr_pkg::S_IDLE : tsr_pkg::S_WORD_RD;
                end
            end
            default: begin
                n_state = tsr_pkg::S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// ----- hdl/tsr_dp.sv -----
`default_nettype none
module tsr_dp (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [tsr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [tsr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic [2:0]                      i_cmd,
    input  wire logic [63:0]                     i_data_word,
    input  wire logic [3:0]                      i_word_bytes,
    input  wire logic                            i_last_word,
    input  wire logic [63:0]                     i_now_ms,
    input  wire logic [9:0]                      i_room,
    input  wire tsr_pkg::t_dp_cmd                i_dcmd,
    output tsr_pkg::t_dp_stat                    o_stat,
    input  wire logic                            i_out_ready,
    output logic                                 o_out_valid,
    output logic [1:0]                           o_status,
    output logic [63:0]                          o_out_word,
    output logic [3:0]                           o_out_bytes,
    output logic                                 o_out_last,
    output logic [9:0]                           o_entry_length,
    output logic [4:0]                           o_stored_count,
    output logic [4:0]                           o_free_slots,
    output logic                                 o_is_full,
    output logic [13:0]                          o_total_bytes,
    output logic [63:0]                          o_oldest_time,
    output logic [63:0]                          o_newest_time,
    output logic [4:0]                           o_removed_count
);
    localparam int SW  = tsr_pkg::SLOT_W;
    localparam int CW  = tsr_pkg::CNT_W;
    localparam int LW  = tsr_pkg::LEN_W;
    localparam int TW  = tsr_pkg::CTR_W;
    localparam int WW  = tsr_pkg::WORD_W;
    localparam int PSW = tsr_pkg::PAY_SLOT_W;
    localparam int PAW = $clog2(tsr_pkg::PAY_DEPTH);
    localparam logic [PSW-1:0] ASM_SLOT = PSW'(tsr_pkg::ENTRY_SLOTS);

    // Configuration registers
    logic [CW-1:0]                  r_lim_cfg;
    logic [LW-1:0]                  r_blim_cfg;
    logic [tsr_pkg::CFG_DATA_W-1:0] r_ret;

    // Ring and assembly state
    logic [SW-1:0]               r_head, r_tail;
    logic [CW-1:0]               r_count;
    logic [tsr_pkg::BYTES_W-1:0] r_bytes;
    logic [TW-1:0]               r_wa;
    logic                        r_ovf;

    // Item being worked on
    logic [2:0]  r_cmd;
    logic [63:0] r_data;
    logic [3:0]  r_wb;
    logic        r_last;
    logic [63:0] r_now;
    logic [9:0]  r_room;

    // Per-item working registers
    tsr_pkg::t_status r_st;
    logic [LW-1:0]    r_len;
    logic [CW-1:0]    r_removed;
    logic [TW-1:0]    r_ctr;
    logic [SW-1:0]    r_rd_slot;

    // Output register
    logic        r_out_valid;
    logic [1:0]  r_o_status;
    logic [63:0] r_o_word;
    logic [3:0]  r_o_bytes;
    logic        r_o_last;
    logic [9:0]  r_o_len;
    logic [4:0]  r_o_count;
    logic [4:0]  r_o_free;
    logic        r_o_full;
    logic [13:0] r_o_bytes_total;
    logic [63:0] r_o_oldest;
    logic [63:0] r_o_newest;
    logic [4:0]  r_o_removed;

    logic [CW-1:0]                lim;
    logic [LW-1:0]                blim;
    logic [SW-1:0]                tail_inc, head_inc, newest;
    logic [3:0]                   wb_sat;
    logic [LW-1:0]                push_len;
    logic [tsr_pkg::META_W-1:0]   meta_rdata;
    logic [63:0]                  newest_rdata;
    logic [LW-1:0]                old_len;
    logic [63:0]                  old_stamp;
    logic [63:0]                  age;
    logic [LW:0]                  len_up;
    logic [LW-3:0]                nwords;
    logic                         word_last;
    logic [3:0]                   word_nbytes;
    logic [LW-1:0]                word_offset;
    logic                         pay_we;
    logic [PAW-1:0]               pay_waddr, pay_raddr;
    logic [63:0]                  pay_wdata, pay_rdata;
    logic                         out_free;

    // Clamp register values and the input word byte count to their usable ranges
    always_comb begin
        lim  = tsr_pkg::eff_limit(r_lim_cfg);
        blim = r_blim_cfg;
        if (r_blim_cfg == '0) blim = LW'(1);
        if (r_blim_cfg > LW'(tsr_pkg::ENTRY_MAX_BYTES)) blim = LW'(tsr_pkg::ENTRY_MAX_BYTES);
        wb_sat = i_word_bytes;
        if (i_word_bytes == 4'd0) wb_sat = 4'd1;
        if (i_word_bytes > 4'd8)  wb_sat = 4'd8;
    end

    assign tail_inc = (CW'(r_tail) + CW'(1) == lim) ? '0 : r_tail + SW'(1);
    assign head_inc = (CW'(r_head) + CW'(1) == lim) ? '0 : r_head + SW'(1);
    assign newest   = (r_head == '0) ? SW'(lim - CW'(1)) : r_head - SW'(1);
    assign push_len = LW'({r_wa, 3'b000}) + LW'(r_wb);

    assign old_len   = meta_rdata[tsr_pkg::META_W-1:tsr_pkg::STAMP_W];
    assign old_stamp = meta_rdata[tsr_pkg::STAMP_W-1:0];
    assign age       = r_now - old_stamp;

    // Word walk of a read-out
    assign len_up      = {1'b0, r_len} + (LW+1)'(7);
    assign nwords      = len_up[LW:3];
    assign word_last   = ((LW-2)'(r_ctr) == nwords - (LW-2)'(1));
    assign word_offset = LW'({r_ctr, 3'b000});
    assign word_nbytes = word_last ? 4'(r_len - word_offset) : 4'd8;

    assign out_free = !r_out_valid || i_out_ready;

    // Payload store addressing
    always_comb begin
        pay_we    = 1'b0;
        pay_waddr = {ASM_SLOT, r_wa[WW-1:0]};
        pay_wdata = r_data;
        if (i_dcmd.asm_push && r_wa < TW'(tsr_pkg::ENTRY_WORDS)) begin
            pay_we = 1'b1;
        end else if (i_dcmd.copy_wr) begin
            pay_we    = 1'b1;
            pay_waddr = {1'b0, r_head, r_ctr[WW-1:0]};
            pay_wdata = pay_rdata;
        end else if (i_dcmd.commit) begin
            pay_we    = 1'b1;
            pay_waddr = {1'b0, r_head, r_wa[WW-1:0]};
            pay_wdata = r_data & tsr_pkg::byte_mask(r_wb);
        end
        pay_raddr = i_dcmd.rd_asm ? {ASM_SLOT, r_ctr[WW-1:0]}
                                  : {1'b0, r_rd_slot, r_ctr[WW-1:0]};
    end

    tsr_ram #(.WIDTH(64), .DEPTH(tsr_pkg::PAY_DEPTH)) u_payload (
        .i_clk   (i_clk),
        .i_we    (pay_we),
        .i_waddr (pay_waddr),
        .i_wdata (pay_wdata),
        .i_raddr (pay_raddr),
        .o_rdata (pay_rdata)
    );

    // Length and stamp, read at the oldest slot
    tsr_ram #(.WIDTH(tsr_pkg::META_W), .DEPTH(tsr_pkg::ENTRY_SLOTS)) u_meta (
        .i_clk   (i_clk),
        .i_we    (i_dcmd.commit),
        .i_waddr (r_head),
        .i_wdata ({push_len, r_now}),
        .i_raddr (r_tail),
        .o_rdata (meta_rdata)
    );

    // Stamp copy, read at the newest slot
    tsr_ram #(.WIDTH(64), .DEPTH(tsr_pkg::ENTRY_SLOTS)) u_stamp (
        .i_clk   (i_clk),
        .i_we    (i_dcmd.commit),
        .i_waddr (r_head),
        .i_wdata (r_now),
        .i_raddr (newest),
        .o_rdata (newest_rdata)
    );

    // Control state: configuration, ring pointers, assembly, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim_cfg   <= tsr_pkg::LIMIT_RESET;
            r_blim_cfg  <= tsr_pkg::BYTE_LIM_RESET;
            r_ret       <= tsr_pkg::RETENTION_RESET;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_bytes     <= '0;
            r_wa        <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (tsr_pkg::t_cfg_idx'(i_cfg_index))
                    tsr_pkg::CFG_ENTRY_LIMIT: begin
                        r_lim_cfg <= i_cfg_data[CW-1:0];
                        // A new effective limit empties the ring
                        if (tsr_pkg::eff_limit(i_cfg_data[CW-1:0]) != lim) begin
                            r_head  <= '0;
                            r_tail  <= '0;
                            r_count <= '0;
                            r_bytes <= '0;
                        end
                    end
                    tsr_pkg::CFG_BYTE_LIMIT: r_blim_cfg <= i_cfg_data[LW-1:0];
                    tsr_pkg::CFG_RETENTION:  r_ret      <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_dcmd.asm_push) begin
                if (r_wa < TW'(tsr_pkg::ENTRY_WORDS)) r_wa <= r_wa + TW'(1);
                else r_ovf <= 1'b1;
            end
            if (i_dcmd.asm_clear || i_dcmd.commit) begin
                r_wa  <= '0;
                r_ovf <= 1'b0;
            end
            if (i_dcmd.remove) begin
                r_tail  <= tail_inc;
                r_count <= r_count - CW'(1);
                r_bytes <= r_bytes - tsr_pkg::BYTES_W'(old_len);
            end
            if (i_dcmd.commit) begin
                r_head  <= head_inc;
                r_count <= r_count + CW'(1);
                r_bytes <= r_bytes + tsr_pkg::BYTES_W'(push_len);
            end
            if (i_dcmd.clear_ring) begin
                r_head  <= '0;
                r_tail  <= '0;
                r_count <= '0;
                r_bytes <= '0;
            end
            if (i_dcmd.load_result || i_dcmd.load_word) r_out_valid <= 1'b1;
            else if (i_out_ready)                       r_out_valid <= 1'b0;
        end
    end

    // Item and working registers
    always_ff @(posedge i_clk) begin
        if (i_dcmd.latch) begin
            r_cmd     <= i_cmd;
            r_data    <= i_data_word;
            r_wb      <= wb_sat;
            r_last    <= i_last_word;
            r_now     <= i_now_ms;
            r_room    <= i_room;
            r_st      <= tsr_pkg::ST_OK;
            r_len     <= '0;
            r_removed <= '0;
        end
        if (i_dcmd.set_st)     r_st      <= i_dcmd.st;
        if (i_dcmd.set_len)    r_len     <= old_len;
        if (i_dcmd.rem_inc)    r_removed <= r_removed + CW'(1);
        if (i_dcmd.clear_ring) r_removed <= r_count;
        if (i_dcmd.save_rd)    r_rd_slot <= r_tail;
        if (i_dcmd.ctr_clr)      r_ctr <= '0;
        else if (i_dcmd.ctr_inc) r_ctr <= r_ctr + TW'(1);
    end

    // Result register with snapshot of the ring
    always_ff @(posedge i_clk) begin
        if (i_dcmd.load_result || i_dcmd.load_word) begin
            r_o_len         <= r_len;
            r_o_count       <= r_count;
            r_o_free        <= lim - r_count;
            r_o_full        <= (r_count >= lim);
            r_o_bytes_total <= r_bytes;
            r_o_oldest      <= (r_count != '0) ? old_stamp : '0;
            r_o_newest      <= (r_count != '0) ? newest_rdata : '0;
        end
        if (i_dcmd.load_result) begin
            r_o_status  <= r_st;
            r_o_word    <= '0;
            r_o_bytes   <= '0;
            r_o_last    <= 1'b1;
            r_o_removed <= r_removed;
        end
        if (i_dcmd.load_word) begin
            r_o_status  <= tsr_pkg::ST_OK;
            r_o_word    <= pay_rdata & tsr_pkg::byte_mask(word_nbytes);
            r_o_bytes   <= word_nbytes;
            r_o_last    <= word_last;
            r_o_removed <= '0;
        end
    end

    assign o_stat.cmd        = tsr_pkg::t_cmd'(r_cmd);
    assign o_stat.last_word  = r_last;
    assign o_stat.reject     = r_ovf || (r_wa >= TW'(tsr_pkg::ENTRY_WORDS)) || (push_len > blim);
    assign o_stat.empty      = (r_count == '0);
    assign o_stat.full       = (r_count >= lim);
    assign o_stat.room_short = (LW'(r_room) < old_len);
    assign o_stat.expire_hit = (r_count != '0) && (age > {32'b0, r_ret});
    assign o_stat.wa_zero    = (r_wa == '0);
    assign o_stat.copy_done  = (r_ctr + TW'(1) == r_wa);
    assign o_stat.word_last  = word_last;
    assign o_stat.out_free   = out_free;

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_o_status;
    assign o_out_word      = r_o_word;
    assign o_out_bytes     = r_o_bytes;
    assign o_out_last      = r_o_last;
    assign o_entry_length  = r_o_len;
    assign o_stored_count  = r_o_count;
    assign o_free_slots    = r_o_free;
    assign o_is_full       = r_o_full;
    assign o_total_bytes   = r_o_bytes_total;
    assign o_oldest_time   = r_o_oldest;
    assign o_newest_time   = r_o_newest;
    assign o_removed_count = r_o_removed;
endmodule
`default_nettype wire

// ----- hdl/timestamped_message_ring.sv -----
// Flow: an accepted item passes look-up and execution and ends in a single result, or for a
//   served pop/peek in its words; a push commit copies earlier words out of the assembly slot.
// Pop/peek: the entry is read out word by word; expire: aged entries are removed one by one.
// Throughput: one item at a time; a new item is accepted only in the idle state.
// Reset: synchronous, active low; clears ring pointers, counts, assembly and the
//   output valid; registers return to 16, 512 and 86400000. Stores are not cleared.
`default_nettype none
module timestamped_message_ring (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [tsr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [tsr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    tsr_in_if.sink                               i_in,
    tsr_out_if.source                            o_out
);
    tsr_pkg::t_dp_cmd  dp_cmd;
    tsr_pkg::t_dp_stat dp_stat;
    logic              in_ready;

    assign i_in.ready = in_ready;

    tsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    tsr_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (i_in.cmd),
        .i_data_word     (i_in.data_word),
        .i_word_bytes    (i_in.word_bytes),
        .i_last_word     (i_in.last_word),
        .i_now_ms        (i_in.now_ms),
        .i_room          (i_in.room),
        .i_dcmd          (dp_cmd),
        .o_stat          (dp_stat),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_status        (o_out.status),
        .o_out_word      (o_out.out_word),
        .o_out_bytes     (o_out.out_bytes),
        .o_out_last      (o_out.out_last),
        .o_entry_length  (o_out.entry_length),
        .o_stored_count  (o_out.stored_count),
        .o_free_slots    (o_out.free_slots),
        .o_is_full       (o_out.is_full),
        .o_total_bytes   (o_out.total_bytes),
        .o_oldest_time   (o_out.oldest_time),
        .o_newest_time   (o_out.newest_time),
        .o_removed_count (o_out.removed_count)
    );

    // A result is only loaded when the output register can take it
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dp_cmd.load_result || dp_cmd.load_word) |-> dp_stat.out_free)
        else $error("result loaded over a pending item");

    // Never two results in one cycle
    a_one_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(dp_cmd.load_result && dp_cmd.load_word))
        else $error("two results loaded at once");

    // No item is taken while a commit, copy or removal is in flight
    a_idle_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ready |-> !(dp_cmd.commit || dp_cmd.copy_wr || dp_cmd.remove))
        else $error("accept during ring update");

    // A completed item is followed by a valid result in the next cycle
    a_result_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.load_result |=> o_out.valid)
        else $error("result not presented");
endmodule
`default_nettype wire
